// ----- hw/rtl/fpcmp_pkg.sv -----
// ----------------------------------------------------------------------------
// fpcmp_pkg
// shared types and constants for the binary64 compare / min / max unit
// ----------------------------------------------------------------------------
`default_nettype none
package fpcmp_pkg;

  localparam int unsigned DataW = 64;

  localparam logic [1:0] OP_CMP  = 2'd0;
  localparam logic [1:0] OP_MIN  = 2'd1;
  localparam logic [1:0] OP_MAX  = 2'd2;
  localparam logic [1:0] OP_RSVD = 2'd3;   // unused code, result is all zero

  localparam logic [3:0] PRED_FALSE = 4'd0;
  localparam logic [3:0] PRED_OEQ   = 4'd1;
  localparam logic [3:0] PRED_OGT   = 4'd2;
  localparam logic [3:0] PRED_OGE   = 4'd3;
  localparam logic [3:0] PRED_OLT   = 4'd4;
  localparam logic [3:0] PRED_OLE   = 4'd5;
  localparam logic [3:0] PRED_ONE   = 4'd6;
  localparam logic [3:0] PRED_ORD   = 4'd7;
  localparam logic [3:0] PRED_UNO   = 4'd8;
  localparam logic [3:0] PRED_UEQ   = 4'd9;
  localparam logic [3:0] PRED_UGT   = 4'd10;
  localparam logic [3:0] PRED_UGE   = 4'd11;
  localparam logic [3:0] PRED_ULT   = 4'd12;
  localparam logic [3:0] PRED_ULE   = 4'd13;
  localparam logic [3:0] PRED_UNE   = 4'd14;
  localparam logic [3:0] PRED_TRUE  = 4'd15;

  localparam logic [63:0] QNAN_CANON = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] EXP_ALL    = 64'h7FF0_0000_0000_0000;

  // request after operand classification
  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  pred;
    logic [63:0] a;
    logic [63:0] b;
    logic        nan;
    logic        both_zero;
    logic [63:0] key_a;
    logic [63:0] key_b;
  } cls_t;

  // request after ordering
  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  pred;
    logic [63:0] a;
    logic [63:0] b;
    logic        nan;
    logic        both_zero;
    logic        lt;   // a < b
    logic        gt;   // b < a
    logic        eq;
  } ord_t;

endpackage
`default_nettype wire

// ----- hw/rtl/fpcmp_classify.sv -----
// ----------------------------------------------------------------------------
// fpcmp_classify
// stage 1: nan / zero detect and order key mapping
// ----------------------------------------------------------------------------
`default_nettype none
module fpcmp_classify import fpcmp_pkg::*; (
  input  wire logic [1:0]  op,
  input  wire logic [3:0]  pred,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output cls_t             cls
);
  always_comb begin
    cls.op        = op;
    cls.pred      = pred;
    cls.a         = a;
    cls.b         = b;
    cls.nan       = ({1'b0, a[62:0]} > EXP_ALL) || ({1'b0, b[62:0]} > EXP_ALL);
    cls.both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
    cls.key_a     = a[63] ? ~a : {1'b1, a[62:0]};
    cls.key_b     = b[63] ? ~b : {1'b1, b[62:0]};
  end
endmodule
`default_nettype wire

// ----- hw/rtl/fpcmp_order.sv -----
// ----------------------------------------------------------------------------
// fpcmp_order
// stage 2: key compare, zeros tie
// ----------------------------------------------------------------------------
`default_nettype none
module fpcmp_order import fpcmp_pkg::*; (
  input  wire cls_t cls,
  output ord_t      ord
);
  always_comb begin
    ord.op        = cls.op;
    ord.pred      = cls.pred;
    ord.a         = cls.a;
    ord.b         = cls.b;
    ord.nan       = cls.nan;
    ord.both_zero = cls.both_zero;
    ord.lt        = !cls.both_zero && (cls.key_a < cls.key_b);
    ord.gt        = !cls.both_zero && (cls.key_b < cls.key_a);
    ord.eq        = (cls.a == cls.b) || cls.both_zero;
  end
endmodule
`default_nettype wire

// ----- hw/rtl/fpcmp_result.sv -----
// ----------------------------------------------------------------------------
// fpcmp_result
// stage 3: predicate evaluation and min / max select
// ----------------------------------------------------------------------------
`default_nettype none
module fpcmp_result import fpcmp_pkg::*; (
  input  wire ord_t         ord,
  output logic              flag,
  output logic [63:0]       selected
);
  logic r;
  always_comb begin
    unique case (ord.pred)
      PRED_FALSE: r = 1'b0;
      PRED_OEQ:   r = !ord.nan && ord.eq;
      PRED_OGT:   r = !ord.nan && ord.gt;
      PRED_OGE:   r = !ord.nan && !ord.lt;
      PRED_OLT:   r = !ord.nan && ord.lt;
      PRED_OLE:   r = !ord.nan && !ord.gt;
      PRED_ONE:   r = !ord.nan && !ord.eq;
      PRED_ORD:   r = !ord.nan;
      PRED_UNO:   r = ord.nan;
      PRED_UEQ:   r = ord.nan || ord.eq;
      PRED_UGT:   r = ord.nan || ord.gt;
      PRED_UGE:   r = ord.nan || !ord.lt;
      PRED_ULT:   r = ord.nan || ord.lt;
      PRED_ULE:   r = ord.nan || !ord.gt;
      PRED_UNE:   r = ord.nan || !ord.eq;
      default:    r = 1'b1;
    endcase
    flag     = 1'b0;
    selected = '0;
    unique case (ord.op)
      OP_CMP: flag = r;
      OP_MIN: begin
        if (ord.nan) selected = QNAN_CANON;
        else if (ord.both_zero) selected = {ord.a[63] | ord.b[63], 63'd0};
        else selected = ord.lt ? ord.a : ord.b;
      end
      OP_MAX: begin
        if (ord.nan) selected = QNAN_CANON;
        else if (ord.both_zero) selected = {ord.a[63] & ord.b[63], 63'd0};
        else selected = ord.lt ? ord.b : ord.a;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- hw/rtl/fp64_compare_min_max.sv -----
// ----------------------------------------------------------------------------
// fp64_compare_min_max
// binary64 compare (16 predicates), ieee minimum and maximum, pipelined
// ----------------------------------------------------------------------------
// channel  | dir | tdata fields (low bit up)                 | tuser
// in_      | in  | op[1:0] operand_a[65:2] operand_b[129:66]  | predicate[3:0]
//          |     | (136 bits, top 6 zero)                     |
// out_     | out | selected[63:0]                             | flag
//
// three register stages: classify, order compare, select; a request passes
// through them in that order, one request per cycle sustained while out_tready is high.
// each stage holds when the stage after it is full and stalled, so a stall
// ripples back without loss or repeat. the last stage is the output
// register. reset clears the stage valid bits only.
`default_nettype none
module fp64_compare_min_max import fpcmp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [135:0] in_tdata,   // op, operand_a, operand_b, pad
  input  wire logic [3:0]   in_tuser,   // predicate
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata,  // selected
  output logic              out_tuser   // flag
);
  // pipeline stage registers
  logic v1_r, v2_r, v3_r;
  cls_t cls_r;
  ord_t ord_r;
  logic flag_r;
  logic [63:0] sel_r;

  cls_t cls_nxt;
  ord_t ord_nxt;
  logic flag_nxt;
  logic [63:0] sel_nxt;
  logic en1, en2, en3;

  // stage enables: a stage loads when it is empty or its content moves on
  assign en3 = !v3_r || out_tready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_tready = en1;

  fpcmp_classify u_cls (
    .op   (in_tdata[1:0]),
    .pred (in_tuser),
    .a    (in_tdata[65:2]),
    .b    (in_tdata[129:66]),
    .cls  (cls_nxt)
  );

  fpcmp_order u_ord (.cls(cls_r), .ord(ord_nxt));

  fpcmp_result u_res (.ord(ord_r), .flag(flag_nxt), .selected(sel_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (en1) cls_r <= cls_nxt;
    if (en2) ord_r <= ord_nxt;
    if (en3) begin
      flag_r <= flag_nxt;
      sel_r  <= sel_nxt;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = sel_r;
  assign out_tuser  = flag_r;
endmodule
`default_nettype wire

// ----- hw/rtl/fpcmp_checker.sv -----
// ----------------------------------------------------------------------------
// fpcmp_props
// port level checks for the compare / min / max unit
// ----------------------------------------------------------------------------
`default_nettype none
module fpcmp_props (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [135:0] in_tdata,
  input wire logic [3:0]   in_tuser,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [63:0]  out_tdata,
  input wire logic         out_tuser
);
  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output changed while stalled");

  // a result carries a flag or a value, never both
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser && (out_tdata != 64'd0)))
    else $error("flag and value both set");

  // a free output side never blocks input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  // accepted request shows on the output when nothing stalls
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready ##1 out_tready ##1 out_tready |=> out_tvalid)
    else $error("result missing");
endmodule

bind fp64_compare_min_max fpcmp_props u_chk (.*);
`default_nettype wire
